// ----- design/ptw_pkg.sv -----
// Shared types and constants for the page table walker.
// No dependencies; imported by ptw_store, ptw_walk and page_table_walker.
package ptw_pkg;

  localparam int VA_W     = 57;
  localparam int WORD_W   = 64;
  localparam int PHYS_W   = 52;
  localparam int IDX_W    = 9;
  localparam int OFS_W    = 12;
  localparam int FRAME_W  = 40;
  localparam int LVL_W    = 3;
  localparam int ST_W     = 2;
  localparam int PAGE_IN_W = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 6;

  localparam logic [WORD_W-1:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_XLATE = 2'd1,
    KIND_REMAP = 2'd2,
    KIND_UNMAP = 2'd3
  } kind_t;

  localparam logic [ST_W-1:0] ST_OK            = 2'd0;
  localparam logic [ST_W-1:0] ST_TABLE_MISSING = 2'd1;
  localparam logic [ST_W-1:0] ST_LEAF_MISSING  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE         = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PAGE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIVE_LEVEL = 1'd1;

  localparam logic [LVL_W-1:0] LVL_NONE = 3'd0;
  localparam logic [LVL_W-1:0] LVL_LEAF = 3'd1;
  localparam logic [LVL_W-1:0] LVL_TOP4 = 3'd4;
  localparam logic [LVL_W-1:0] LVL_TOP5 = 3'd5;

  // 9-bit table index of a virtual address at a given level (1 = leaf)
  function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                input logic [LVL_W-1:0] level);
    logic [IDX_W-1:0] idx;
    case (level)
      3'd2:    idx = va[29:21];
      3'd3:    idx = va[38:30];
      3'd4:    idx = va[47:39];
      3'd5:    idx = va[56:48];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ----- design/ptw_store.sv -----
// Table store: single-port-write, single-port-read synchronous RAM.
// Read data is registered. Uses ptw_pkg for the word width.
module ptw_store
  import ptw_pkg::*;
#(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/ptw_walk.sv -----
// Walk sequencer: clears the store after reset, runs table-word writes and
// walks, does the leaf read-modify-write, and holds the result register.
// Uses ptw_pkg; drives the ports of ptw_store.
module ptw_walk
  import ptw_pkg::*;
#(
  parameter int TABLE_PAGES = 64,
  parameter int PW          = 6,
  parameter int AW          = 15,
  parameter int DEPTH       = 32768
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PAGE_IN_W-1:0] root_page,
  input  logic                 five_level,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic [VA_W-1:0]      vaddr,
  input  logic [PAGE_IN_W-1:0] table_page,
  input  logic [IDX_W-1:0]     table_slot,
  input  logic [WORD_W-1:0]    word,
  input  logic [WORD_W-1:0]    new_flags,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ST_W-1:0]      status,
  output logic [PHYS_W-1:0]    paddr,
  output logic [LVL_W-1:0]     fail_level,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [WORD_W-1:0]    mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  logic [WORD_W-1:0]    mem_rdata
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_WALK   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  localparam logic [FRAME_W-1:0] PAGES = FRAME_W'(TABLE_PAGES);
  localparam logic [AW-1:0]      LAST  = AW'(DEPTH - 1);

  state_t              state, state_next;
  logic [AW-1:0]       clr_addr;
  logic [LVL_W-1:0]    level, level_next;
  kind_t               op;
  logic [VA_W-1:0]     va;
  logic [WORD_W-1:0]   flags;
  logic [AW-1:0]       cur_addr;
  logic [ST_W-1:0]     res_status;
  logic [PHYS_W-1:0]   res_phys;
  logic [LVL_W-1:0]    res_level;

  logic                accept, slot_free;
  logic [LVL_W-1:0]    top_lvl;
  logic                root_ok, page_ok, present, frame_ok;
  logic [FRAME_W-1:0]  frame;
  logic                fin;
  logic [ST_W-1:0]     fin_status;
  logic [PHYS_W-1:0]   fin_phys;
  logic [LVL_W-1:0]    fin_level;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign top_lvl   = five_level ? LVL_TOP5 : LVL_TOP4;
  assign root_ok   = {{(FRAME_W-PAGE_IN_W){1'b0}}, root_page} < PAGES;
  assign page_ok   = {{(FRAME_W-PAGE_IN_W){1'b0}}, table_page} < PAGES;
  assign present   = mem_rdata[0];
  assign frame     = mem_rdata[51:12];
  assign frame_ok  = frame < PAGES;

  always_comb begin
    state_next = state;
    level_next = level;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_phys   = '0;
    fin_level  = LVL_NONE;
    mem_we     = 1'b0;
    mem_waddr  = cur_addr;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = {PW'(root_page), va_index(vaddr, top_lvl)};
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (kind_t'(kind) == KIND_WRITE) begin
            mem_we    = page_ok;
            mem_waddr = {PW'(table_page), table_slot};
            mem_wdata = word;
            fin       = 1'b1;
          end else if (!root_ok) begin
            fin        = 1'b1;
            fin_status = ST_RANGE;
            fin_level  = top_lvl;
          end else begin
            mem_re     = 1'b1;
            level_next = top_lvl;
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (level != LVL_LEAF) begin
          if (!present) begin
            fin        = 1'b1;
            fin_status = ST_TABLE_MISSING;
            fin_level  = level;
          end else if (!frame_ok) begin
            fin        = 1'b1;
            fin_status = ST_RANGE;
            fin_level  = level;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = {frame[PW-1:0], va_index(va, level - 3'd1)};
            level_next = level - 3'd1;
          end
        end else if (!present) begin
          fin        = 1'b1;
          fin_status = ST_LEAF_MISSING;
          fin_level  = LVL_LEAF;
        end else begin
          fin = 1'b1;
          case (op)
            KIND_XLATE: fin_phys = {frame, va[OFS_W-1:0]};
            KIND_REMAP: begin
              mem_we    = 1'b1;
              mem_wdata = (mem_rdata & FRAME_MASK) | flags;
            end
            default: mem_we = 1'b1;
          endcase
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (fin) begin
      state_next = slot_free ? S_IDLE : S_FINISH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (fin && slot_free) begin
        out_valid <= 1'b1;
      end else if ((state == S_FINISH) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    level <= level_next;
    if (accept) begin
      op    <= kind_t'(kind);
      va    <= vaddr;
      flags <= new_flags;
    end
    if (mem_re) begin
      cur_addr <= mem_raddr;
    end
    if (fin) begin
      res_status <= fin_status;
      res_phys   <= fin_phys;
      res_level  <= fin_level;
    end
    if (fin && slot_free) begin
      status     <= fin_status;
      paddr      <= fin_phys;
      fail_level <= fin_level;
    end else if ((state == S_FINISH) && slot_free) begin
      status     <= res_status;
      paddr      <= res_phys;
      fail_level <= res_level;
    end
  end

endmodule

// ----- design/page_table_walker.sv -----
// Top level of the page table walker: configuration registers, walk
// sequencer (ptw_walk) and table store RAM (ptw_store). Uses ptw_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item: kind selects a
//   table-word write, translate, remap or unmap. Output channel
//   (out_valid/out_ready) returns exactly one result item per input item,
//   in order: status, paddr, fail_level.
//   Config port: cfg_we writes cfg_data into register cfg_index at the clock
//   edge (0 = root_page, 1 = five_level); write only while no item is open.
// Sequence from accept to result in the output register:
//   table-word write or root out of range: the result is formed as the
//   item is accepted. Walk: the top-level read is issued on accept, then
//   each level checked issues the read of the next, down to the leaf.
//   All table reads go through the single read port of the store, one
//   dependent entry per cycle.
//   Remap and unmap write the leaf back in the cycle it is checked.
// Throughput: one item at a time; the next item is taken the cycle after a
//   result is handed to the output register.
// Reset: rst (synchronous) clears the config registers and starts a
//   clearing pass that zeroes all TABLE_PAGES*512 store entries, one per
//   cycle (32768 entries at the default); in_ready stays low until it ends.
// Stall: a result waiting on out_ready is held in the output register while
//   the next item is accepted and walked; that item's result is parked until
//   the output register frees up.
module page_table_walker
  import ptw_pkg::*;
#(
  parameter int TABLE_PAGES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic [VA_W-1:0]      vaddr,
  input  logic [PAGE_IN_W-1:0] table_page,
  input  logic [IDX_W-1:0]     table_slot,
  input  logic [WORD_W-1:0]    word,
  input  logic [WORD_W-1:0]    new_flags,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ST_W-1:0]      status,
  output logic [PHYS_W-1:0]    paddr,
  output logic [LVL_W-1:0]     fail_level
);

  // page index width and store geometry follow from the page count
  localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int AW    = PW + IDX_W;
  localparam int DEPTH = TABLE_PAGES * (1 << IDX_W);

  logic [PAGE_IN_W-1:0] root_page;
  logic                 five_level;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_W-1:0]    mem_wdata, mem_rdata;

  // config registers, written directly with no handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      root_page  <= '0;
      five_level <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROOT_PAGE:  root_page  <= cfg_data;
        CFG_FIVE_LEVEL: five_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ptw_walk #(
    .TABLE_PAGES (TABLE_PAGES),
    .PW          (PW),
    .AW          (AW),
    .DEPTH       (DEPTH)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .root_page  (root_page),
    .five_level (five_level),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .vaddr      (vaddr),
    .table_page (table_page),
    .table_slot (table_slot),
    .word       (word),
    .new_flags  (new_flags),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .paddr      (paddr),
    .fail_level (fail_level),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ptw_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
